>>> rtl/edf_pkg.sv
// ----------------------------------------------------------------------------
// EDF scheduler package
// Operation codes, status codes and queue entry types shared by the block.
// ----------------------------------------------------------------------------
package edf_pkg;

   typedef enum logic [2:0] {
      K_CREATE   = 3'd0,
      K_TERM     = 3'd1,
      K_SLEEP    = 3'd2,
      K_SETDL    = 3'd3,
      K_TICK     = 3'd4,
      K_SETTICK  = 3'd5,
      K_RUN      = 3'd6
   } kind_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   localparam logic [31:0] IDLE_DEADLINE = 32'hFFFF_FFFF;
   localparam logic [3:0]  IDLE_ID       = 4'd0;

   // Entry of the ready queue.
   typedef struct packed {
      logic [3:0]  id;
      logic [31:0] dl;
   } ready_entry_type;

   // Entry of the timer queue; also the working item of an insert.
   typedef struct packed {
      logic [3:0]  id;
      logic [31:0] dl;
      logic [31:0] wake;
   } sleep_entry_type;

endpackage

>>> rtl/edf_req_if.sv
// ----------------------------------------------------------------------------
// EDF scheduler request channel
// Valid/ready channel that carries one scheduler operation per beat.
// ----------------------------------------------------------------------------
interface edf_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [3:0]  task_id;
   logic [31:0] value;

   modport source (output valid, kind, task_id, value, input ready);
   modport sink   (input valid, kind, task_id, value, output ready);
endinterface

>>> rtl/edf_rsp_if.sv
// ----------------------------------------------------------------------------
// EDF scheduler response channel
// Valid/ready channel that carries one scheduler result per beat.
// ----------------------------------------------------------------------------
interface edf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  running_task;
   logic        switch_needed;
   logic [31:0] tick_now;
   logic [4:0]  ready_entries;
   logic [4:0]  sleeping_entries;

   modport source (output valid, status, running_task, switch_needed, tick_now,
                   ready_entries, sleeping_entries, input ready);
   modport sink   (input valid, status, running_task, switch_needed, tick_now,
                   ready_entries, sleeping_entries, output ready);
endinterface

>>> rtl/edf_task_scheduler.sv
// ----------------------------------------------------------------------------
// EDF task scheduler
// Deadline-sorted ready queue and timer queue held in two synchronous memories.
// ----------------------------------------------------------------------------
// Each request beat on req carries one operation (create, terminate, sleep,
// set deadline, tick, set ticks, run). Exactly one response beat on rsp
// follows it, reporting status, head task, switch flag, tick count and the
// occupancy of both queues.
// The block works on one request at a time. Queue moves go one entry at a
// time through the memory read and write ports: a pop shifts every entry
// behind the head one place toward it, and a sorted insert moves each entry
// with a later deadline one place up before writing the item into its slot.
// A simple operation goes from S_IDLE straight to S_DONE, where its response
// is registered once the output register is free; a set deadline first pops
// the head and then inserts it anew. After reset the block writes the idle
// task into entry zero of the ready queue before req.ready rises.
// The response sits in an output register. While the receiver stalls, the
// next request is still accepted and processed; its response waits until
// the previous beat has been taken.
// ----------------------------------------------------------------------------
module edf_task_scheduler
   import edf_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic       clock,
   input  logic       reset,
   edf_req_if.sink    req,
   edf_rsp_if.source  rsp
);

   localparam int AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNTW = $clog2(MAX_TASKS + 1);
   localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_TASKS);
   localparam logic [CNTW-1:0] CNT_ONE = CNTW'(1);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_POP_RD, S_POP_WR, S_INS_RD, S_INS_WR, S_DONE
   } state_type;

   // Memories: the ready queue and the timer queue.
   ready_entry_type rmem [MAX_TASKS];
   sleep_entry_type smem [MAX_TASKS];

   ready_entry_type r_rd_ff;
   sleep_entry_type s_rd_ff;
   logic [AW-1:0]   r_ra, s_ra, r_wa, s_wa;
   logic            r_we, s_we;
   ready_entry_type r_wd;
   sleep_entry_type s_wd;

   always_ff @(posedge clock) begin
      if (r_we) begin
         rmem[r_wa] <= r_wd;
      end
      r_rd_ff <= rmem[r_ra];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         smem[s_wa] <= s_wd;
      end
      s_rd_ff <= smem[s_ra];
   end

   // Control and working registers.
   state_type       state_ff, state_in;
   logic            mode_ff, mode_in;
   logic [31:0]     tick_ff, tick_in;
   logic [CNTW-1:0] rcnt_ff, rcnt_in, scnt_ff, scnt_in;
   ready_entry_type rhead_ff, rhead_in;
   sleep_entry_type shead_ff, shead_in;
   logic [2:0]      kind_ff, kind_in;
   logic [1:0]      st_ff, st_in;
   logic            pop_q_ff, pop_q_in;       // 0 ready queue, 1 timer queue
   logic            ins_q_ff, ins_q_in;
   logic            ins_pend_ff, ins_pend_in;
   sleep_entry_type item_ff, item_in;
   logic [CNTW-1:0] idx_ff, idx_in, lim_ff, lim_in;
   logic            repl_ff, repl_in;
   logic            was_run_ff, was_run_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic [3:0]      rsp_task_ff, rsp_task_in;
   logic            rsp_switch_ff, rsp_switch_in;
   logic [31:0]     rsp_tick_ff, rsp_tick_in;
   logic [4:0]      rsp_rcnt_ff, rsp_rcnt_in, rsp_scnt_ff, rsp_scnt_in;

   logic            accept;
   logic [31:0]     tick_next;
   logic [31:0]     cur_dl;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign tick_next = tick_ff + 32'd1;
   assign cur_dl    = ins_q_ff ? s_rd_ff.dl : r_rd_ff.dl;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      tick_in       = tick_ff;
      rcnt_in       = rcnt_ff;
      scnt_in       = scnt_ff;
      rhead_in      = rhead_ff;
      shead_in      = shead_ff;
      kind_in       = kind_ff;
      st_in         = st_ff;
      pop_q_in      = pop_q_ff;
      ins_q_in      = ins_q_ff;
      ins_pend_in   = ins_pend_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      lim_in        = lim_ff;
      repl_in       = repl_ff;
      was_run_in    = was_run_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_switch_in = rsp_switch_ff;
      rsp_tick_in   = rsp_tick_ff;
      rsp_rcnt_in   = rsp_rcnt_ff;
      rsp_scnt_in   = rsp_scnt_ff;
      r_we = 1'b0;
      s_we = 1'b0;
      r_wa = '0;
      s_wa = '0;
      r_ra = '0;
      s_ra = '0;
      r_wd = '{id: IDLE_ID, dl: IDLE_DEADLINE};
      s_wd = item_ff;

      case (state_ff)
         S_INIT: begin
            // Place the idle task at the head of the ready queue.
            r_we     = 1'b1;
            state_in = S_IDLE;
         end

         S_IDLE: begin
            if (accept) begin
               kind_in     = req.kind;
               st_in       = ST_OK;
               repl_in     = 1'b0;
               ins_pend_in = 1'b0;
               was_run_in  = mode_ff;
               state_in    = S_DONE;
               case (req.kind)
                  K_CREATE: begin
                     if (req.task_id == IDLE_ID) begin
                        st_in = ST_INVALID;
                     end else if (rcnt_ff >= CNT_MAX) begin
                        st_in = ST_FULL;
                     end else begin
                        ins_q_in = 1'b0;
                        item_in  = '{id: req.task_id, dl: req.value, wake: '0};
                        idx_in   = rcnt_ff;
                        rcnt_in  = rcnt_ff + CNT_ONE;
                        state_in = S_INS_RD;
                     end
                  end
                  K_TERM, K_SLEEP, K_SETDL: begin
                     if (rhead_ff.id == IDLE_ID) begin
                        st_in = ST_INVALID;
                     end else if (req.kind == K_SLEEP && scnt_ff >= CNT_MAX) begin
                        st_in = ST_FULL;
                     end else begin
                        pop_q_in = 1'b0;
                        idx_in   = CNT_ONE;
                        lim_in   = rcnt_ff;
                        rcnt_in  = rcnt_ff - CNT_ONE;
                        state_in = S_POP_RD;
                        if (req.kind == K_SLEEP) begin
                           repl_in     = 1'b1;
                           ins_pend_in = 1'b1;
                           ins_q_in    = 1'b1;
                           item_in     = '{id: rhead_ff.id, dl: rhead_ff.dl,
                                           wake: tick_ff + req.value};
                        end else if (req.kind == K_SETDL) begin
                           ins_pend_in = 1'b1;
                           ins_q_in    = 1'b0;
                           item_in     = '{id: rhead_ff.id, dl: req.value, wake: '0};
                        end else begin
                           repl_in = 1'b1;
                        end
                     end
                  end
                  K_TICK: begin
                     tick_in = tick_next;
                     if (scnt_ff != '0 &&
                         (shead_ff.wake < tick_next || shead_ff.dl < tick_next)) begin
                        if (rcnt_ff >= CNT_MAX) begin
                           st_in = ST_FULL;
                        end else begin
                           pop_q_in    = 1'b1;
                           idx_in      = CNT_ONE;
                           lim_in      = scnt_ff;
                           scnt_in     = scnt_ff - CNT_ONE;
                           ins_pend_in = 1'b1;
                           ins_q_in    = 1'b0;
                           item_in     = '{id: shead_ff.id, dl: shead_ff.dl, wake: '0};
                           state_in    = S_POP_RD;
                        end
                     end
                  end
                  K_SETTICK: begin
                     tick_in = req.value;
                  end
                  K_RUN: begin
                     tick_in = '0;
                     mode_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_POP_RD: begin
            if (idx_ff >= lim_ff) begin
               if (ins_pend_ff) begin
                  state_in = S_INS_RD;
                  if (ins_q_ff) begin
                     idx_in  = scnt_ff;
                     scnt_in = scnt_ff + CNT_ONE;
                  end else begin
                     idx_in  = rcnt_ff;
                     rcnt_in = rcnt_ff + CNT_ONE;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               r_ra     = AW'(idx_ff);
               s_ra     = AW'(idx_ff);
               state_in = S_POP_WR;
            end
         end

         S_POP_WR: begin
            // Shift the entry just read one place toward the head.
            r_wa     = AW'(idx_ff - CNT_ONE);
            s_wa     = AW'(idx_ff - CNT_ONE);
            r_wd     = r_rd_ff;
            s_wd     = s_rd_ff;
            r_we     = !pop_q_ff;
            s_we     = pop_q_ff;
            idx_in   = idx_ff + CNT_ONE;
            state_in = S_POP_RD;
         end

         S_INS_RD: begin
            if (idx_ff == '0) begin
               r_wa     = '0;
               s_wa     = '0;
               r_wd     = '{id: item_ff.id, dl: item_ff.dl};
               s_wd     = item_ff;
               r_we     = !ins_q_ff;
               s_we     = ins_q_ff;
               if (kind_ff != K_SLEEP) begin
                  repl_in = (kind_ff != K_SETDL);
               end
               state_in = S_DONE;
            end else begin
               r_ra     = AW'(idx_ff - CNT_ONE);
               s_ra     = AW'(idx_ff - CNT_ONE);
               state_in = S_INS_WR;
            end
         end

         S_INS_WR: begin
            r_wa = AW'(idx_ff);
            s_wa = AW'(idx_ff);
            r_we = !ins_q_ff;
            s_we = ins_q_ff;
            if (cur_dl > item_ff.dl) begin
               // Entry below is later than the item: move it up and keep walking.
               r_wd     = r_rd_ff;
               s_wd     = s_rd_ff;
               idx_in   = idx_ff - CNT_ONE;
               state_in = S_INS_RD;
            end else begin
               r_wd     = '{id: item_ff.id, dl: item_ff.dl};
               s_wd     = item_ff;
               if (kind_ff != K_SLEEP) begin
                  repl_in = (kind_ff == K_SETDL);
               end
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_task_in   = rhead_ff.id;
               rsp_switch_in = was_run_ff && repl_ff;
               rsp_tick_in   = tick_ff;
               rsp_rcnt_in   = 5'(rcnt_ff);
               rsp_scnt_in   = 5'(scnt_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Head copies follow every write to entry zero.
      if (r_we && r_wa == '0) begin
         rhead_in = r_wd;
      end
      if (s_we && s_wa == '0) begin
         shead_in = s_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         mode_ff      <= 1'b0;
         tick_ff      <= '0;
         rcnt_ff      <= CNT_ONE;
         scnt_ff      <= '0;
         rhead_ff     <= '{id: IDLE_ID, dl: IDLE_DEADLINE};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         tick_ff      <= tick_in;
         rcnt_ff      <= rcnt_in;
         scnt_ff      <= scnt_in;
         rhead_ff     <= rhead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shead_ff      <= shead_in;
      kind_ff       <= kind_in;
      st_ff         <= st_in;
      pop_q_ff      <= pop_q_in;
      ins_q_ff      <= ins_q_in;
      ins_pend_ff   <= ins_pend_in;
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      lim_ff        <= lim_in;
      repl_ff       <= repl_in;
      was_run_ff    <= was_run_in;
      rsp_status_ff <= rsp_status_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_switch_ff <= rsp_switch_in;
      rsp_tick_ff   <= rsp_tick_in;
      rsp_rcnt_ff   <= rsp_rcnt_in;
      rsp_scnt_ff   <= rsp_scnt_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.status           = rsp_status_ff;
   assign rsp.running_task     = rsp_task_ff;
   assign rsp.switch_needed    = rsp_switch_ff;
   assign rsp.tick_now         = rsp_tick_ff;
   assign rsp.ready_entries    = rsp_rcnt_ff;
   assign rsp.sleeping_entries = rsp_scnt_ff;

endmodule

>>> rtl/edf_checker.sv
// ----------------------------------------------------------------------------
// EDF scheduler port checker
// Checks the response channel of the scheduler as seen at its ports.
// ----------------------------------------------------------------------------
module edf_checker
   import edf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_switch_needed,
   input logic [4:0] rsp_ready_entries
);

   // A stalled response beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // No response beat right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat after reset");

   // The idle task is always in the ready queue.
   a_idle_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ready_entries != 5'd0)
      else $error("ready queue reported empty");

   // A refused operation never asks for a context switch.
   a_no_switch_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_switch_needed)
      else $error("switch flagged on a refused operation");

endmodule

bind edf_task_scheduler edf_checker u_edf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_status        (rsp.status),
   .rsp_switch_needed (rsp.switch_needed),
   .rsp_ready_entries (rsp.ready_entries)
);
